>>> rtl/core/lbp_pkg.sv
// Shared constants and types for the lossless bitmap pixel converter.
// No dependencies; used by the channel interfaces and the top level.
package lbp_pkg;

    localparam int CH_W            = 8;
    localparam int BYTES_W         = 32;
    localparam int SLOT_W          = 8;
    localparam int CNT_W           = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 9;
    localparam int NUMER_W         = 16;
    localparam int NUM_CH          = 3;
    localparam int DIV_STAGES      = 4;
    localparam int STEPS_PER_STAGE = 2;
    localparam int PALETTE_DEPTH_DEFAULT = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 2'd2;

    localparam logic [1:0] FMT_COLORMAP = 2'd0;
    localparam logic [1:0] FMT_RGB15    = 2'd1;
    localparam logic [1:0] FMT_RGB32    = 2'd2;

    localparam logic [CNT_W-1:0] PAL_COUNT_RESET = 9'd256;
    localparam logic [CH_W-1:0]  CH_MAX          = 8'hFF;
    localparam logic [4:0]       FIVE_MASK       = 5'h1F;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] pre;       // red, green, blue when not divided
        logic [CH_W-1:0]             alpha;
        logic                        missed;
        logic                        last;
        logic                        use_div;
        logic [NUM_CH-1:0]           sat;
        logic [NUM_CH-1:0][CH_W-1:0] rem;
        logic [NUM_CH-1:0][CH_W-1:0] low;
        logic [NUM_CH-1:0][CH_W-1:0] quo;
        logic [CH_W-1:0]             divisor;
    } lbp_stage_t;

endpackage

>>> rtl/core/lbp_channels.sv
// Channel interfaces for the lossless bitmap pixel converter.
// Depends on lbp_pkg for field widths.
interface lbp_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [lbp_pkg::SLOT_W-1:0]   palette_slot;
    logic [lbp_pkg::BYTES_W-1:0]  entry_bytes;
    logic [lbp_pkg::BYTES_W-1:0]  pixel_bytes;
    logic                         last_pixel;

    modport source (output valid, kind, palette_slot, entry_bytes, pixel_bytes, last_pixel,
                    input ready);
    modport sink   (input valid, kind, palette_slot, entry_bytes, pixel_bytes, last_pixel,
                    output ready);
endinterface

interface lbp_out_if;
    logic                      valid;
    logic                      ready;
    logic [lbp_pkg::CH_W-1:0]  red;
    logic [lbp_pkg::CH_W-1:0]  green;
    logic [lbp_pkg::CH_W-1:0]  blue;
    logic [lbp_pkg::CH_W-1:0]  alpha;
    logic                      index_missed;
    logic                      image_end;

    modport source (output valid, red, green, blue, alpha, index_missed, image_end,
                    input ready);
    modport sink   (input valid, red, green, blue, alpha, index_missed, image_end,
                    output ready);
endinterface

>>> rtl/core/lossless_bitmap_pixel_to_rgba_top.sv
// Lossless bitmap pixel converter: palette store, format decode and
// un-premultiply divider pipeline. Depends on lbp_pkg and lbp_channels.
//
// Usage:
//   pixel_chan carries transactions of two kinds: palette writes (kind 0),
//   which load one palette slot and give no result, and pixels (kind 1),
//   each giving exactly one RGBA transaction on rgba_chan in order.
//   Configuration (format, version, palette count) is written through
//   cfg_we / cfg_index / cfg_data while no pixel is in flight.
//   On the way from pixel acceptance to rgba_chan.valid, the input register
//   with the palette read is loaded at the accepting edge, then follow one
//   prepare stage for the 255*c + a/2 numerators, four divider stages of two
//   quotient bits each, and the output register. Throughput is one
//   transaction per cycle while rgba_chan does not stall the pipeline.
//   When rgba_chan.ready is low with a result waiting, the whole pipeline
//   holds and pixel_chan.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and sets format 0, version one and a
//   palette count of 256. The palette contents are undefined until written.
module lossless_bitmap_pixel_to_rgba_top
    #(parameter int PALETTE_DEPTH = lbp_pkg::PALETTE_DEPTH_DEFAULT)
    (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]   cfg_data,
    lbp_in_if.sink                           pixel_chan,
    lbp_out_if.source                        rgba_chan
    );

    import lbp_pkg::*;

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_LIMIT = CNT_W'(PALETTE_DEPTH);

    logic [1:0]       pixel_format_reg;
    logic             version_two_reg;
    logic [CNT_W-1:0] palette_count_reg;

    logic [BYTES_W-1:0] palette_mem [PALETTE_DEPTH];
    logic [BYTES_W-1:0] pal_rd_reg;

    logic               s0_valid_reg;
    logic               s0_kind_reg;
    logic [BYTES_W-1:0] s0_pix_reg;
    logic               s0_last_reg;

    logic       p_valid_reg [DIV_STAGES+1];
    lbp_stage_t p_reg       [DIV_STAGES+1];
    lbp_stage_t p_next      [DIV_STAGES+1];

    logic          out_valid_reg;
    logic [CH_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic [CH_W-1:0] red_next, green_next, blue_next;
    logic          missed_reg, end_reg;

    logic advance;
    logic accept;

    assign advance = !out_valid_reg || rgba_chan.ready;
    assign pixel_chan.ready = advance;
    assign accept = pixel_chan.valid && advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg  <= FMT_COLORMAP;
            version_two_reg   <= 1'b0;
            palette_count_reg <= PAL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PIXEL_FORMAT:  pixel_format_reg  <= cfg_data[1:0];
                CFG_VERSION_TWO:   version_two_reg   <= cfg_data[0];
                CFG_PALETTE_COUNT: palette_count_reg <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // palette store
    always_ff @(posedge clk)
    begin
        if (accept && !pixel_chan.kind && ({1'b0, pixel_chan.palette_slot} < DEPTH_LIMIT))
        begin
            palette_mem[pixel_chan.palette_slot[ADDR_W-1:0]] <= pixel_chan.entry_bytes;
        end
        if (advance)
        begin
            pal_rd_reg <= palette_mem[pixel_chan.pixel_bytes[ADDR_W-1:0]];
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= pixel_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_kind_reg <= pixel_chan.kind;
            s0_pix_reg  <= pixel_chan.pixel_bytes;
            s0_last_reg <= pixel_chan.last_pixel;
        end
    end

    // prepare stage and divider steps
    always_comb
    begin
        logic [CH_W-1:0] b0;
        logic [NUM_CH-1:0][CH_W-1:0] cols;
        logic [CH_W:0] t;
        logic hit;

        b0 = s0_pix_reg[7:0];
        cols[0] = s0_pix_reg[15:8];
        cols[1] = s0_pix_reg[23:16];
        cols[2] = s0_pix_reg[31:24];
        hit = ({1'b0, b0} < palette_count_reg) && ({1'b0, b0} < DEPTH_LIMIT);

        p_next[0] = '0;
        p_next[0].last    = s0_last_reg;
        p_next[0].divisor = b0;

        case (pixel_format_reg)
            FMT_COLORMAP:
            begin
                if (hit)
                begin
                    p_next[0].pre[0] = pal_rd_reg[7:0];
                    p_next[0].pre[1] = pal_rd_reg[15:8];
                    p_next[0].pre[2] = pal_rd_reg[23:16];
                    p_next[0].alpha  = version_two_reg ? pal_rd_reg[31:24] : CH_MAX;
                end
                else
                begin
                    p_next[0].missed = 1'b1;
                end
            end
            FMT_RGB15:
            begin
                if (!version_two_reg)
                begin
                    p_next[0].pre[0] = {s0_pix_reg[14:10], s0_pix_reg[14:12]};
                    p_next[0].pre[1] = {s0_pix_reg[9:5], s0_pix_reg[9:7]};
                    p_next[0].pre[2] = {s0_pix_reg[4:0], s0_pix_reg[4:2]};
                    p_next[0].alpha  = CH_MAX;
                end
            end
            FMT_RGB32:
            begin
                if (!version_two_reg)
                begin
                    p_next[0].pre   = cols;
                    p_next[0].alpha = CH_MAX;
                end
                else if (b0 != '0)
                begin
                    p_next[0].use_div = 1'b1;
                    p_next[0].alpha   = b0;
                end
            end
            default: ;
        endcase

        for (int c = 0; c < NUM_CH; c++)
        begin
            logic [NUMER_W-1:0] numer;
            numer = {cols[c], 8'h00} - NUMER_W'(cols[c]) + NUMER_W'(b0 >> 1);
            p_next[0].sat[c] = cols[c] >= b0;
            p_next[0].rem[c] = numer[15:8];
            p_next[0].low[c] = numer[7:0];
        end

        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            p_next[s] = p_reg[s-1];
            for (int c = 0; c < NUM_CH; c++)
            begin
                for (int k = 0; k < STEPS_PER_STAGE; k++)
                begin
                    t = {p_next[s].rem[c], p_next[s].low[c][CH_W-1]};
                    p_next[s].low[c] = {p_next[s].low[c][CH_W-2:0], 1'b0};
                    if (t >= {1'b0, p_next[s].divisor})
                    begin
                        t = t - {1'b0, p_next[s].divisor};
                        p_next[s].quo[c] = {p_next[s].quo[c][CH_W-2:0], 1'b1};
                    end
                    else
                    begin
                        p_next[s].quo[c] = {p_next[s].quo[c][CH_W-2:0], 1'b0};
                    end
                    p_next[s].rem[c] = t[CH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                p_valid_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            p_valid_reg[0] <= s0_valid_reg && s0_kind_reg;
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                p_valid_reg[s] <= p_valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                p_reg[s] <= p_next[s];
            end
        end
    end

    // output register
    always_comb
    begin
        lbp_stage_t f;
        logic [NUM_CH-1:0][CH_W-1:0] ch;
        f = p_reg[DIV_STAGES];
        for (int c = 0; c < NUM_CH; c++)
        begin
            ch[c] = !f.use_div ? f.pre[c] : (f.sat[c] ? CH_MAX : f.quo[c]);
        end
        red_next   = ch[0];
        green_next = ch[1];
        blue_next  = ch[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= p_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            alpha_reg  <= p_reg[DIV_STAGES].alpha;
            missed_reg <= p_reg[DIV_STAGES].missed;
            end_reg    <= p_reg[DIV_STAGES].last;
        end
    end

    assign rgba_chan.valid        = out_valid_reg;
    assign rgba_chan.red          = red_reg;
    assign rgba_chan.green        = green_reg;
    assign rgba_chan.blue         = blue_reg;
    assign rgba_chan.alpha        = alpha_reg;
    assign rgba_chan.index_missed = missed_reg;
    assign rgba_chan.image_end    = end_reg;

endmodule

>>> verif/lossless_bitmap_pixel_to_rgba_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the lossless bitmap pixel converter: random and directed pixel and
// palette streams under random valid/ready idling, checked against an in-bench predictor.
// Depends on lbp_pkg, lbp_channels and lossless_bitmap_pixel_to_rgba_top.
module lossless_bitmap_pixel_to_rgba_top_test;
    import lbp_pkg::*;

    localparam logic       KIND_PALETTE = 1'b0;
    localparam logic       KIND_PIXEL   = 1'b1;
    localparam logic [1:0] FMT_RESERVED = 2'd3;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         LIMIT_CYCLES  = 400000;

    typedef struct packed {
        logic                kind;
        logic [SLOT_W-1:0]   palette_slot;
        logic [BYTES_W-1:0]  entry_bytes;
        logic [BYTES_W-1:0]  pixel_bytes;
        logic                last_pixel;
    } pixel_req_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            index_missed;
        logic            image_end;
    } rgba_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lbp_in_if  pixel_chan ();
    lbp_out_if rgba_chan ();

    lossless_bitmap_pixel_to_rgba_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_chan (pixel_chan),
        .rgba_chan  (rgba_chan)
    );

    // predictor state
    logic [BYTES_W-1:0] shade_table [256];
    logic [1:0]         cur_format = FMT_COLORMAP;
    logic               cur_v2     = 1'b0;
    logic [CNT_W-1:0]   cur_count  = PAL_COUNT_RESET;

    pixel_req_t pending_items [$];
    rgba_t      expected_rgba [$];
    bit         slot_loaded [256];

    pixel_req_t offered;
    bit         accepted;
    int         gap_left;
    int         stall_left;
    int         hold_left;
    int         hold_requests;
    int         holds_served;
    bit         send_idle;
    bit         recv_idle;
    int         errors;
    int         pixels_checked;
    int         misses_seen;
    int         palette_loads;
    int         settings_used;
    int         cycle_count;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [CH_W-1:0] widen5(logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [CH_W-1:0] straight_channel(logic [CH_W-1:0] c, logic [CH_W-1:0] a);
        int q;
        q = (int'(c) * 255 + int'(a) / 2) / int'(a);
        return (q > 255) ? CH_MAX : q[CH_W-1:0];
    endfunction

    function automatic rgba_t predict_rgba(pixel_req_t req);
        rgba_t              res;
        logic [CH_W-1:0]    b0;
        logic [CH_W-1:0]    b1;
        logic [CH_W-1:0]    b2;
        logic [CH_W-1:0]    b3;
        logic [BYTES_W-1:0] entry;
        res = '0;
        {b3, b2, b1, b0} = req.pixel_bytes;
        res.image_end = req.last_pixel;
        case (cur_format)
            FMT_COLORMAP:
            begin
                if ({1'b0, b0} < cur_count)
                begin
                    entry = shade_table[b0];
                    res.red   = entry[7:0];
                    res.green = entry[15:8];
                    res.blue  = entry[23:16];
                    res.alpha = cur_v2 ? entry[31:24] : CH_MAX;
                end
                else
                begin
                    res.index_missed = 1'b1;
                end
            end
            FMT_RGB15:
            begin
                if (!cur_v2)
                begin
                    res.red   = widen5(req.pixel_bytes[14:10] & FIVE_MASK);
                    res.green = widen5(req.pixel_bytes[9:5] & FIVE_MASK);
                    res.blue  = widen5(req.pixel_bytes[4:0] & FIVE_MASK);
                    res.alpha = CH_MAX;
                end
            end
            FMT_RGB32:
            begin
                if (!cur_v2)
                begin
                    res.red   = b1;
                    res.green = b2;
                    res.blue  = b3;
                    res.alpha = CH_MAX;
                end
                else if (b0 != 0)
                begin
                    res.red   = straight_channel(b1, b0);
                    res.green = straight_channel(b2, b0);
                    res.blue  = straight_channel(b3, b0);
                    res.alpha = b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (pixel %0d)",
                     what, got, want, pixels_checked);
    endtask

    // driver: offer queued transactions, idling between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            accepted = pixel_chan.valid && pixel_chan.ready;
            if (accepted)
            begin
                if (offered.kind == KIND_PALETTE)
                begin
                    shade_table[offered.palette_slot] = offered.entry_bytes;
                    palette_loads++;
                end
                else
                begin
                    expected_rgba.insert(expected_rgba.size(), predict_rgba(offered));
                end
                gap_left = send_idle ? $urandom_range(0, 10) : 0;
            end
            if (pixel_chan.valid && !accepted)
            begin
                // hold the offered transaction
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                pixel_chan.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                offered = pending_items.pop_front();
                pixel_chan.kind         <= offered.kind;
                pixel_chan.palette_slot <= offered.palette_slot;
                pixel_chan.entry_bytes  <= offered.entry_bytes;
                pixel_chan.pixel_bytes  <= offered.pixel_bytes;
                pixel_chan.last_pixel   <= offered.last_pixel;
                pixel_chan.valid        <= 1'b1;
            end
            else
            begin
                pixel_chan.valid <= 1'b0;
            end
        end
    end

    // monitor: check results and stall the output side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rgba_chan.valid && rgba_chan.ready)
            begin
                if (expected_rgba.size() == 0)
                begin
                    report_mismatch("unexpected transaction",
                                    int'({rgba_chan.red, rgba_chan.green, rgba_chan.blue,
                                          rgba_chan.alpha}), 0);
                end
                else
                begin
                    rgba_t want;
                    want = expected_rgba.pop_front();
                    if (rgba_chan.red !== want.red)
                        report_mismatch("red", int'(rgba_chan.red), int'(want.red));
                    if (rgba_chan.green !== want.green)
                        report_mismatch("green", int'(rgba_chan.green), int'(want.green));
                    if (rgba_chan.blue !== want.blue)
                        report_mismatch("blue", int'(rgba_chan.blue), int'(want.blue));
                    if (rgba_chan.alpha !== want.alpha)
                        report_mismatch("alpha", int'(rgba_chan.alpha), int'(want.alpha));
                    if (rgba_chan.index_missed !== want.index_missed)
                        report_mismatch("index_missed", int'(rgba_chan.index_missed),
                                        int'(want.index_missed));
                    if (rgba_chan.image_end !== want.image_end)
                        report_mismatch("image_end", int'(rgba_chan.image_end),
                                        int'(want.image_end));
                    if (want.index_missed)
                        misses_seen++;
                end
                pixels_checked++;
                stall_left = recv_idle ? $urandom_range(0, 10) : 0;
            end
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = $urandom_range(60, 100);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rgba_chan.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rgba_chan.ready <= 1'b0;
            end
            else
            begin
                rgba_chan.ready <= 1'b1;
            end
        end
    end

    task automatic push_write(input logic [SLOT_W-1:0] slot, input logic [BYTES_W-1:0] entry);
        pixel_req_t req;
        req.kind         = KIND_PALETTE;
        req.palette_slot = slot;
        req.entry_bytes  = entry;
        req.pixel_bytes  = $urandom;
        req.last_pixel   = 1'($urandom_range(0, 1));
        slot_loaded[slot] = 1'b1;
        pending_items.insert(pending_items.size(), req);
    endtask

    task automatic push_pixel(input logic [BYTES_W-1:0] bytes, input logic last);
        pixel_req_t req;
        req.kind         = KIND_PIXEL;
        req.palette_slot = SLOT_W'($urandom);
        req.entry_bytes  = $urandom;
        req.pixel_bytes  = bytes;
        req.last_pixel   = last;
        pending_items.insert(pending_items.size(), req);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || pixel_chan.valid || expected_rgba.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PIXEL_FORMAT:  cur_format = value[1:0];
            CFG_VERSION_TWO:   cur_v2     = value[0];
            CFG_PALETTE_COUNT: cur_count  = value;
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic [1:0] fmt, input logic v2, input logic [CNT_W-1:0] count);
        wait_idle();
        write_reg(CFG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
        write_reg(CFG_VERSION_TWO, CFG_DATA_W'(v2));
        write_reg(CFG_PALETTE_COUNT, count);
        settings_used++;
    endtask

    function automatic logic [BYTES_W-1:0] random_entry();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_random_pixel();
        logic [BYTES_W-1:0] bytes;
        logic [CH_W-1:0]    a;
        logic [CH_W-1:0]    idx;
        int                 pick;
        bytes = $urandom;
        if ($urandom_range(0, 7) == 0)
            push_write(SLOT_W'($urandom), random_entry());
        if (cur_format == FMT_COLORMAP)
        begin
            if (cur_count != 0 && $urandom_range(0, 9) < 7)
                idx = CH_W'($urandom_range(0, (cur_count > 256) ? 255 : cur_count - 1));
            else
                idx = CH_W'($urandom);
            // load the slot first so that no unwritten entry is read
            if ({1'b0, idx} < cur_count && !slot_loaded[idx])
                push_write(idx, random_entry());
            bytes[7:0] = idx;
        end
        else if (cur_format == FMT_RGB32 && cur_v2)
        begin
            pick = $urandom_range(0, 24);
            a = (pick < 2) ? 8'd0 : (pick < 4) ? CH_MAX : (pick == 4) ? 8'd1 : CH_W'($urandom);
            bytes[7:0] = a;
            if ($urandom_range(0, 9) < 6)
            begin
                bytes[15:8]  = CH_W'($urandom_range(0, a));
                bytes[23:16] = CH_W'($urandom_range(0, a));
                bytes[31:24] = CH_W'($urandom_range(0, a));
            end
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            bytes = $urandom_range(0, 1) ? '1 : '0;
        end
        push_pixel(bytes, $urandom_range(0, 15) == 0);
    endtask

    initial
    begin
        logic [1:0]       fmt;
        logic             v2;
        logic [CNT_W-1:0] count;
        int               n;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        pixel_chan.valid        = 1'b0;
        pixel_chan.kind         = KIND_PALETTE;
        pixel_chan.palette_slot = '0;
        pixel_chan.entry_bytes  = '0;
        pixel_chan.pixel_bytes  = '0;
        pixel_chan.last_pixel   = 1'b0;
        rgba_chan.ready         = 1'b0;
        send_idle               = 1'b1;
        recv_idle               = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset mode: colormap, version one, full palette
        push_write(8'd0, 32'h44332211);
        push_write(8'd255, 32'hFFFFFFFF);
        push_write(8'd1, 32'h00000000);
        push_pixel(32'hFFFFFF00, 1'b0);
        push_pixel(32'h000000FF, 1'b0);
        push_pixel(32'h5A5A5A01, 1'b1);
        set_mode(FMT_COLORMAP, 1'b1, 9'd256);
        push_pixel(32'h00000000, 1'b0);
        push_pixel(32'h000000FF, 1'b1);
        set_mode(FMT_COLORMAP, 1'b1, 9'd1);
        push_pixel(32'h00000001, 1'b0);
        push_pixel(32'h00000000, 1'b1);
        set_mode(FMT_COLORMAP, 1'b0, 9'd0);
        push_pixel(32'h00000000, 1'b1);
        set_mode(FMT_RGB15, 1'b0, 9'd256);
        push_pixel(32'h00007FFF, 1'b0);
        push_pixel(32'hFFFF8000, 1'b0);
        push_pixel(32'h00004210, 1'b1);
        set_mode(FMT_RGB15, 1'b1, 9'd256);
        push_pixel(32'h00007FFF, 1'b1);
        set_mode(FMT_RGB32, 1'b0, 9'd256);
        push_pixel(32'hFFFFFFFF, 1'b0);
        push_pixel(32'h00000000, 1'b1);
        set_mode(FMT_RGB32, 1'b1, 9'd256);
        push_pixel(32'hFFFFFF00, 1'b0);
        push_pixel(32'hFFFFFF01, 1'b0);
        push_pixel(32'h804020FF, 1'b0);
        push_pixel(32'h10204080, 1'b1);
        set_mode(FMT_RESERVED, 1'b0, 9'd256);
        push_pixel(32'hFFFFFFFF, 1'b1);

        for (int p = 0; p < 14; p++)
        begin
            case (p)
                0: begin fmt = FMT_COLORMAP; v2 = 1'b0; count = 9'd256; end
                1: begin fmt = FMT_COLORMAP; v2 = 1'b1; count = 9'd256; end
                2: begin fmt = FMT_COLORMAP; v2 = 1'b1; count = 9'd1;   end
                3: begin fmt = FMT_COLORMAP; v2 = 1'b0; count = 9'd0;   end
                4: begin fmt = FMT_RGB15;    v2 = 1'b0; count = 9'd255; end
                5: begin fmt = FMT_RGB32;    v2 = 1'b0; count = 9'd256; end
                6: begin fmt = FMT_RGB32;    v2 = 1'b1; count = 9'd128; end
                7: begin fmt = FMT_RGB15;    v2 = 1'b1; count = 9'd256; end
                8: begin fmt = FMT_RESERVED; v2 = 1'b0; count = 9'd256; end
                default:
                begin
                    n = $urandom_range(0, 9);
                    fmt = (n < 4) ? FMT_COLORMAP : (n < 6) ? FMT_RGB15 :
                          (n < 9) ? FMT_RGB32 : FMT_RESERVED;
                    v2 = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 5))
                        0:       count = 9'd0;
                        1:       count = 9'd1;
                        2:       count = 9'd256;
                        3:       count = 9'd255;
                        default: count = CNT_W'($urandom_range(2, 254));
                    endcase
                end
            endcase
            set_mode(fmt, v2, count);
            send_idle = (p % 3 != 0);
            recv_idle = (p % 4 != 1);
            n = (fmt == FMT_RESERVED || (fmt == FMT_RGB15 && v2)) ? 40 : 120;
            for (int i = 0; i < n; i++)
                push_random_pixel();
            // long output hold while the sender keeps offering
            if (p % 3 == 0)
                hold_requests++;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Checked %0d RGBA transactions (%0d index misses) and %0d palette loads",
                 pixels_checked, misses_seen, palette_loads);
        $display("over %0d register settings covering all formats, both versions %s",
                 settings_used, "and counts 0 to 256");
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lbp_pkg.sv
rtl/core/lbp_channels.sv
rtl/core/lossless_bitmap_pixel_to_rgba_top.sv
verif/lossless_bitmap_pixel_to_rgba_top_test.sv
